FILE: src/vrt_pkg.sv
// Package with transaction types and constants shared by the voxel ray traversal block.
package vrt_pkg;

	localparam int CELL_W = 12;
	localparam int SLEN_W = 32;
	localparam int DIST_W = 44;
	localparam int LIM_W  = 10;
	localparam logic [LIM_W-1:0] LIMIT_RESET = 10'd1000;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	typedef logic signed [CELL_W-1:0] cell_t;
	typedef logic [SLEN_W-1:0] slen_t;
	typedef logic [DIST_W-1:0] dist_t;

	typedef struct packed {
		logic               operation;
		logic [4:0]         cell_x;
		logic [4:0]         cell_y;
		logic [4:0]         cell_z;
		logic               solid_bit;
		logic signed [23:0] origin_x;
		logic signed [23:0] origin_y;
		logic signed [23:0] origin_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic               stop_before;
	} vrt_req_t;

	typedef struct packed {
		logic signed [11:0] hit_x;
		logic signed [11:0] hit_y;
		logic signed [11:0] hit_z;
		logic               found;
		logic [9:0]         steps_taken;
	} vrt_rsp_t;

endpackage

FILE: src/vrt_occ_mem.sv
// Occupancy memory: one row of cells per (z, y), cleared row by row after reset.
module vrt_occ_mem import vrt_pkg::*; #(
	parameter int GRID_SIZE = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  rd_en,
	input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] rd_addr,
	output logic [GRID_SIZE-1:0]                  rd_data,
	input  logic                                  wr_en,
	input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] wr_addr,
	input  logic [GRID_SIZE-1:0]                  wr_data,
	output logic                                  busy
);

	localparam int ROWS  = GRID_SIZE * GRID_SIZE;
	localparam int RAW   = $clog2(ROWS);
	localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);

	logic [GRID_SIZE-1:0] mem [ROWS];
	logic [RAW-1:0]       clr_q;
	logic                 busy_q;

	// sweep all rows once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == LAST_ROW) begin
				busy_q <= 1'b0;
			end
		end
	end

	// single write port, shared with the clearing sweep
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign busy = busy_q;

endmodule

FILE: src/vrt_setup.sv
// Ray set-up unit: norm, bit-serial square root, shared divider and start distances.
module vrt_setup import vrt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [2:0][15:0]        dir,
	input  logic [2:0][15:0]        frac,
	output logic                    done,
	output slen_t [2:0]             step_len,
	output dist_t [2:0]             bdist
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_NORM = 5'b00010,
		S_ROOT = 5'b00100,
		S_LOAD = 5'b01000,
		S_DIV  = 5'b10000
	} sst_t;

	sst_t        state_q;
	logic [1:0]  axis_q;
	logic [4:0]  iter_q;
	logic [31:0] norm_q;
	logic [31:0] rad_q;
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic [31:0] dq_q;
	logic [16:0] drem_q;
	logic        done_q;
	logic        mul_q;

	logic signed [15:0] d_cur;
	logic signed [31:0] sq;
	logic [31:0]        norm_nx;
	logic [34:0]        rem_sh;
	logic [34:0]        trial;
	logic [16:0]        mag;
	logic [16:0]        dr_sh;
	logic               d_pos;
	logic [16:0]        f_cur;
	logic [48:0]        prod;

	// per-axis operands
	always_comb begin
		d_cur   = $signed(dir[axis_q]);
		sq      = d_cur * d_cur;
		norm_nx = norm_q + sq;
		rem_sh  = {rem_q[32:0], rad_q[31:30]};
		trial   = {1'b0, root_q, 2'b01};
		mag     = d_cur[15] ? 17'(-$signed({d_cur[15], d_cur})) : 17'(d_cur);
		dr_sh   = {drem_q[15:0], dq_q[31]};
		d_pos   = !d_cur[15] && (d_cur != '0);
		f_cur   = d_pos ? (17'h10000 - 17'(frac[axis_q])) : 17'(frac[axis_q]);
		prod    = 49'(dq_q) * 49'(f_cur);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= '0;
			iter_q  <= '0;
			done_q  <= 1'b0;
			mul_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_NORM;
						axis_q  <= '0;
					end
				end
				S_NORM: begin
					if (axis_q == 2'd2) begin
						state_q <= S_ROOT;
						iter_q  <= '0;
					end else begin
						axis_q <= axis_q + 1'b1;
					end
				end
				S_ROOT: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == 5'd31) begin
						state_q <= S_LOAD;
						axis_q  <= '0;
					end
				end
				S_LOAD: begin
					iter_q <= '0;
					mul_q  <= 1'b0;
					if (d_cur != '0) begin
						state_q <= S_DIV;
					end else if (axis_q == 2'd2) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						axis_q <= axis_q + 1'b1;
					end
				end
				S_DIV: begin
					if (mul_q) begin
						if (axis_q == 2'd2) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else begin
							axis_q  <= axis_q + 1'b1;
							state_q <= S_LOAD;
						end
					end else begin
						iter_q <= iter_q + 1'b1;
						if (iter_q == 5'd31) begin
							mul_q <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				norm_q <= '0;
			end
			S_NORM: begin
				norm_q <= norm_nx;
				if (axis_q == 2'd2) begin
					rad_q  <= norm_nx;
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			S_ROOT: begin
				rad_q <= {rad_q[29:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			S_LOAD: begin
				dq_q   <= root_q;
				drem_q <= '0;
				if (d_cur == '0) begin
					step_len[axis_q] <= '0;
					bdist[axis_q]    <= '0;
				end
			end
			S_DIV: begin
				if (mul_q) begin
					step_len[axis_q] <= dq_q;
					bdist[axis_q]    <= DIST_W'(prod[48:16]);
				end else if (dr_sh >= mag) begin
					drem_q <= dr_sh - mag;
					dq_q   <= {dq_q[30:0], 1'b1};
				end else begin
					drem_q <= dr_sh;
					dq_q   <= {dq_q[30:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;

endmodule

FILE: src/voxel_ray_traversal.sv
// Voxel ray traversal: top level with transaction handshake, walk sequencer and result register.
// Write item: row read, modify, write back, then the result.
// Cast item: set-up (norm, 32-step square root, one divide per nonzero axis), then traversal
// steps (one occupancy row read each), up to the configured step limit, then the result.
// After reset the occupancy memory is cleared one row a cycle, all GRID_SIZE*GRID_SIZE rows
// (1024 at the default size); no transaction is accepted until the sweep ends.
module voxel_ray_traversal import vrt_pkg::*; #(
	parameter int GRID_SIZE = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  vrt_req_t         req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output vrt_rsp_t         rsp,
	input  logic             cfg_we,
	input  logic [LIM_W-1:0] cfg_wdata
);

	localparam int CW  = $clog2(GRID_SIZE);
	localparam int RAW = $clog2(GRID_SIZE * GRID_SIZE);
	localparam logic [RAW-1:0]    G_ROW  = RAW'(GRID_SIZE);
	localparam logic [CELL_W-1:0] G_CELL = CELL_W'(GRID_SIZE);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_WR_RD = 7'b0000010,
		ST_WR_WB = 7'b0000100,
		ST_SETUP = 7'b0001000,
		ST_STEP  = 7'b0010000,
		ST_CHECK = 7'b0100000,
		ST_DONE  = 7'b1000000
	} st_t;

	st_t              state_q;
	vrt_req_t         req_q;
	logic [LIM_W-1:0] limit_q;
	logic [LIM_W-1:0] count_q;
	logic             found_q;
	logic             start_q;
	logic [1:0]       best_q;
	logic             ingrid_q;
	cell_t            cell_q [3];
	dist_t            dist_q [3];
	slen_t            slen_q [3];
	vrt_rsp_t         rsp_q;
	logic             rsp_valid_q;

	logic                 mem_busy;
	logic                 rd_en;
	logic [RAW-1:0]       rd_addr;
	logic [GRID_SIZE-1:0] rd_data;
	logic                 wr_en;
	logic [RAW-1:0]       wr_addr;
	logic [GRID_SIZE-1:0] wr_data;

	logic             su_done;
	slen_t [2:0]      su_slen;
	dist_t [2:0]      su_dist;
	logic [2:0][15:0] dir_a;
	logic [2:0][15:0] frac_a;
	logic [2:0]       live;

	logic       accept;
	logic       wr_in_grid;
	logic [1:0] sel;
	dist_t      sel_d;
	logic       sel_ok;
	logic       sel_pos;
	cell_t      cell_nx [3];
	logic       nx_in_grid;
	logic       solid;
	logic       rsp_load;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE) && !mem_busy;
	assign dir_a     = {req_q.dir_z, req_q.dir_y, req_q.dir_x};
	assign frac_a    = {req_q.origin_z[15:0], req_q.origin_y[15:0], req_q.origin_x[15:0]};
	assign live      = {req_q.dir_z != '0, req_q.dir_y != '0, req_q.dir_x != '0};

	vrt_occ_mem #(.GRID_SIZE(GRID_SIZE)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.busy    (mem_busy)
	);

	vrt_setup u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dir      (dir_a),
		.frac     (frac_a),
		.done     (su_done),
		.step_len (su_slen),
		.bdist    (su_dist)
	);

	// pick the axis with the nearest boundary, ties go x, y, z
	always_comb begin
		sel    = 2'd0;
		sel_d  = dist_q[0];
		sel_ok = live[0];
		if (live[1] && (!sel_ok || dist_q[1] < sel_d)) begin
			sel    = 2'd1;
			sel_d  = dist_q[1];
			sel_ok = 1'b1;
		end
		if (live[2] && (!sel_ok || dist_q[2] < sel_d)) begin
			sel = 2'd2;
		end
		sel_pos = !dir_a[sel][15];
		for (int a = 0; a < 3; a++) begin
			cell_nx[a] = cell_q[a];
		end
		cell_nx[sel] = sel_pos ? cell_q[sel] + 1'b1 : cell_q[sel] - 1'b1;
		nx_in_grid = 1'b1;
		for (int a = 0; a < 3; a++) begin
			if (cell_nx[a][CELL_W-1] || (cell_nx[a] >= G_CELL)) begin
				nx_in_grid = 1'b0;
			end
		end
	end

	// occupancy accesses
	always_comb begin
		wr_in_grid = (CELL_W'(req_q.cell_x) < G_CELL) && (CELL_W'(req_q.cell_y) < G_CELL)
			&& (CELL_W'(req_q.cell_z) < G_CELL);
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = RAW'(req_q.cell_z) * G_ROW + RAW'(req_q.cell_y);
		wr_data = rd_data;
		wr_data[CW'(req_q.cell_x)] = req_q.solid_bit;
		if (state_q == ST_WR_RD) begin
			rd_en   = wr_in_grid;
			rd_addr = wr_addr;
		end else if (state_q == ST_STEP) begin
			rd_en   = nx_in_grid;
			rd_addr = RAW'(cell_nx[2]) * G_ROW + RAW'(cell_nx[1]);
		end
		if (state_q == ST_WR_WB) begin
			wr_en = wr_in_grid;
		end
		solid = ingrid_q && rd_data[CW'(cell_q[0])];
	end

	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.operation == OP_WRITE) begin
							state_q <= ST_WR_RD;
						end else begin
							state_q <= ST_SETUP;
							start_q <= 1'b1;
						end
					end
				end
				ST_WR_RD: state_q <= ST_WR_WB;
				ST_WR_WB: state_q <= ST_DONE;
				ST_SETUP: begin
					if (su_done) begin
						state_q <= ((live != '0) && (limit_q != '0)) ? ST_STEP : ST_DONE;
					end
				end
				ST_STEP: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (solid || (count_q >= limit_q)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req;
			count_q   <= '0;
			found_q   <= 1'b0;
			cell_q[0] <= CELL_W'($signed(req.origin_x[23:16]));
			cell_q[1] <= CELL_W'($signed(req.origin_y[23:16]));
			cell_q[2] <= CELL_W'($signed(req.origin_z[23:16]));
		end
		if (state_q == ST_SETUP && su_done) begin
			for (int a = 0; a < 3; a++) begin
				slen_q[a] <= su_slen[a];
				dist_q[a] <= su_dist[a];
			end
		end
		if (state_q == ST_STEP) begin
			dist_q[sel] <= dist_q[sel] + DIST_W'(slen_q[sel]);
			for (int a = 0; a < 3; a++) begin
				cell_q[a] <= cell_nx[a];
			end
			best_q   <= sel;
			ingrid_q <= nx_in_grid;
			count_q  <= count_q + 1'b1;
		end
		if (state_q == ST_CHECK && solid) begin
			found_q <= 1'b1;
			if (req_q.stop_before) begin
				cell_q[best_q] <= dir_a[best_q][15] ? cell_q[best_q] + 1'b1
					: cell_q[best_q] - 1'b1;
			end
		end
		if (rsp_load) begin
			if (req_q.operation == OP_WRITE) begin
				rsp_q <= '0;
			end else begin
				rsp_q.hit_x       <= cell_q[0];
				rsp_q.hit_y       <= cell_q[1];
				rsp_q.hit_z       <= cell_q[2];
				rsp_q.found       <= found_q;
				rsp_q.steps_taken <= count_q;
			end
		end
	end

	// result register, holds until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_found_has_steps: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |-> rsp.steps_taken != '0)
		else $error("found result with zero steps");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !mem_busy)
		else $error("transaction accepted during memory clear");

	a_count_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> (count_q != '0) && (count_q <= limit_q))
		else $error("step count outside limit");

endmodule

FILE: dv/voxel_ray_traversal_tb.sv
// Self-checking testbench for the voxel ray traversal block.
module voxel_ray_traversal_tb;
	import vrt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID = 32;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	vrt_req_t req;
	logic rsp_valid;
	logic rsp_ready;
	vrt_rsp_t rsp;
	logic cfg_we;
	logic [LIM_W-1:0] cfg_wdata;

	voxel_ray_traversal #(.GRID_SIZE(GRID)) uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// Shadow state of the block
	bit grid_solid [GRID*GRID*GRID];
	logic [LIM_W-1:0] walk_limit;

	vrt_req_t pending_reqs[$];
	vrt_rsp_t expected_hits[$];
	int mismatches;
	int accepted;
	bit quiet_tail;
	int req_gap;
	int rsp_gap;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit solid_at(longint x, longint y, longint z);
		if (x < 0 || x >= GRID || y < 0 || y >= GRID || z < 0 || z >= GRID) begin
			return 1'b0;
		end
		return grid_solid[(z * GRID + y) * GRID + x];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Compute the cell a transaction reports and update the shadow grid
	function automatic vrt_rsp_t trace_ray(vrt_req_t t);
		vrt_rsp_t r;
		longint pos [3];
		longint dir [3];
		longint unsigned bnd [3];
		longint unsigned slen [3];
		longint unsigned frac;
		longint unsigned fdist;
		longint unsigned norm2;
		longint unsigned root;
		longint orig;
		int best;
		int count;
		bit hit;
		r = '0;
		if (t.operation == OP_WRITE) begin
			grid_solid[(int'(t.cell_z) * GRID + int'(t.cell_y)) * GRID + int'(t.cell_x)] =
				t.solid_bit;
			return r;
		end
		norm2 = 0;
		for (int a = 0; a < 3; a++) begin
			orig = (a == 0) ? longint'(t.origin_x) : (a == 1) ? longint'(t.origin_y)
				: longint'(t.origin_z);
			dir[a] = (a == 0) ? longint'(t.dir_x) : (a == 1) ? longint'(t.dir_y)
				: longint'(t.dir_z);
			frac = orig & 64'hFFFF;
			pos[a] = orig >>> 16;
			bnd[a] = frac;
			norm2 += dir[a] * dir[a];
		end
		root = int_sqrt(norm2 << 32);
		for (int a = 0; a < 3; a++) begin
			if (dir[a] != 0) begin
				fdist = (dir[a] > 0) ? 65536 - bnd[a] : bnd[a];
				slen[a] = root / longint'(dir[a] < 0 ? -dir[a] : dir[a]);
				bnd[a] = (slen[a] * fdist) >> 16;
			end else begin
				slen[a] = 0;
				bnd[a] = 0;
			end
		end
		count = 0;
		hit = 1'b0;
		if (dir[0] != 0 || dir[1] != 0 || dir[2] != 0) begin
			while (count < walk_limit) begin
				best = -1;
				for (int a = 0; a < 3; a++) begin
					if (dir[a] != 0 && (best < 0 || bnd[a] < bnd[best])) best = a;
				end
				bnd[best] += slen[best];
				pos[best] += (dir[best] > 0) ? 1 : -1;
				count++;
				if (solid_at(pos[0], pos[1], pos[2])) begin
					hit = 1'b1;
					if (t.stop_before) pos[best] -= (dir[best] > 0) ? 1 : -1;
					break;
				end
			end
		end
		r.hit_x = pos[0][11:0];
		r.hit_y = pos[1][11:0];
		r.hit_z = pos[2][11:0];
		r.found = hit;
		r.steps_taken = count[9:0];
		return r;
	endfunction

	function automatic vrt_req_t cell_write(int x, int y, int z, bit s);
		vrt_req_t t;
		t = '0;
		t.operation = OP_WRITE;
		t.cell_x = 5'(x);
		t.cell_y = 5'(y);
		t.cell_z = 5'(z);
		t.solid_bit = s;
		t.origin_x = 24'($urandom);
		t.dir_y = 16'($urandom);
		return t;
	endfunction

	function automatic vrt_req_t ray_cast(int ox, int oy, int oz, int dx, int dy, int dz,
		bit sb);
		vrt_req_t t;
		t = '0;
		t.operation = OP_CAST;
		t.cell_x = 5'($urandom);
		t.solid_bit = 1'($urandom);
		t.origin_x = 24'(ox);
		t.origin_y = 24'(oy);
		t.origin_z = 24'(oz);
		t.dir_x = 16'(dx);
		t.dir_y = 16'(dy);
		t.dir_z = 16'(dz);
		t.stop_before = sb;
		return t;
	endfunction

	// Random ray, mostly starting inside or near the grid
	function automatic vrt_req_t random_ray();
		int o [3];
		int d [3];
		for (int a = 0; a < 3; a++) begin
			if ($urandom_range(0, 9) == 0) o[a] = $urandom;
			else o[a] = $urandom_range(0, (GRID + 8) * 65536) - 4 * 65536;
			case ($urandom_range(0, 7))
				0: d[a] = 0;
				1: d[a] = $urandom_range(0, 1) ? 16'sh7FFF : -32768;
				2: d[a] = $urandom_range(0, 1) ? 1 : -1;
				default: d[a] = $signed(16'($urandom));
			endcase
		end
		return ray_cast(o[0], o[1], o[2], d[0], d[1], d[2], 1'($urandom_range(0, 1)));
	endfunction

	// Drive request transactions from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			req_gap <= 0;
		end else if (req_valid && !req_ready) begin
			// hold
		end else if (req_gap > 0) begin
			req_valid <= 1'b0;
			req_gap <= req_gap - 1;
		end else if (pending_reqs.size() > 0) begin
			if (req_valid && !quiet_tail && $urandom_range(0, 5) == 0) begin
				req_valid <= 1'b0;
				req_gap <= $urandom_range(0, 4);
			end else begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
			end
		end else begin
			req_valid <= 1'b0;
		end
	end

	// Predict on acceptance
	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) begin
			expected_hits.push_back(trace_ray(req));
			accepted++;
		end
	end

	// Monitor result transactions and apply backpressure
	always @(posedge clk or negedge arst_n) begin
		vrt_rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_gap <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_hits.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", rsp);
				end else begin
					want = expected_hits.pop_front();
					if (rsp !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected %p actual %p", want, rsp);
						end
					end
				end
			end
			if (rsp_gap > 0) begin
				rsp_gap <= rsp_gap - 1;
				rsp_ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				rsp_gap <= $urandom_range(0, 4);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	task automatic drain();
		wait (pending_reqs.size() == 0 && !req_valid && expected_hits.size() == 0
			&& accepted > 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_limit(logic [LIM_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		walk_limit = v;
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 2) == 0) begin
				pending_reqs.push_back(cell_write($urandom_range(0, 31),
					$urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 3) != 0));
			end else begin
				pending_reqs.push_back(random_ray());
			end
		end
		drain();
	endtask

	// Stimulus
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		mismatches = 0;
		accepted = 0;
		quiet_tail = 1'b0;
		walk_limit = LIMIT_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero direction, miss on empty grid, ties, writes, stop before
		pending_reqs.push_back(ray_cast(5 * 65536, 5 * 65536, 5 * 65536, 0, 0, 0, 0));
		pending_reqs.push_back(ray_cast(0, 0, 0, 16384, 16384, 16384, 0));
		pending_reqs.push_back(cell_write(31, 31, 31, 1));
		pending_reqs.push_back(cell_write(0, 0, 0, 1));
		pending_reqs.push_back(cell_write(10, 3, 3, 1));
		pending_reqs.push_back(ray_cast(3 * 65536, 3 * 65536, 3 * 65536, 16384, 0, 0, 0));
		pending_reqs.push_back(ray_cast(3 * 65536, 3 * 65536, 3 * 65536, 16384, 0, 0, 1));
		pending_reqs.push_back(ray_cast(0, 0, 0, -16384, 0, 0, 0));
		pending_reqs.push_back(ray_cast(20 * 65536, 3 * 65536 + 32768, 3 * 65536 + 32768,
			-32768, 0, 0, 1));
		pending_reqs.push_back(ray_cast(28 * 65536 + 32768, 28 * 65536 + 32768,
			28 * 65536 + 32768, 16384, 16384, 16384, 0));
		pending_reqs.push_back(ray_cast(-8388608, 8388607, -8388608, 32767, -32768, 1, 1));
		pending_reqs.push_back(ray_cast(8388607, -8388608, 8388607, -1, 32767, -32768, 0));
		pending_reqs.push_back(ray_cast(0, 0, 65535, 0, 0, -1, 0));
		pending_reqs.push_back(cell_write(0, 0, 0, 0));
		pending_reqs.push_back(ray_cast(32768, 32768, 32768, -16384, -16384, -16384, 0));
		drain();

		// Extreme limits, then mid settings
		set_limit(10'd1);
		random_phase(40);
		set_limit(10'd1023);
		random_phase(120);
		set_limit(10'd0);
		random_phase(20);
		set_limit(10'($urandom_range(2, 200)));
		random_phase(150);
		set_limit(10'd64);
		quiet_tail = 1'b1;
		random_phase(170);

		if (mismatches == 0 && expected_hits.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(200_000_000ns);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: files.f
src/vrt_pkg.sv
src/vrt_occ_mem.sv
src/vrt_setup.sv
src/voxel_ray_traversal.sv
dv/voxel_ray_traversal_tb.sv
